/* rtl/mhp_pkg.sv */
// ----------------------------------------------------------------------------
// mhp_pkg: shared definitions for the message padder
// Constants, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mhp_pkg;

  // hash block geometry
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);

  // stream and length field geometry
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned BUF_W       = 56;
  localparam int unsigned FILL_W      = 3;
  localparam int unsigned COUNT_W     = 61;
  localparam int unsigned LEN_BYTES   = 8;

  // trailer size limits
  localparam int unsigned TRAIL_W     = 5;
  localparam logic [TRAIL_W-1:0] TRAIL_MIN = TRAIL_W'(8);
  localparam logic [TRAIL_W-1:0] TRAIL_MAX = TRAIL_W'(16);

  // padding marker byte
  localparam logic [7:0] PAD_MARK = 8'h80;

  // input item operations
  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // configuration port
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRAILER_BYTES = 2'd0,
    CFG_LENGTH_LE     = 2'd1
  } cfg_idx_e;

  // finish sequencer, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MARK  = 4'b0010,
    ST_ZERO  = 4'b0100,
    ST_TRAIL = 4'b1000
  } state_e;

endpackage : mhp_pkg

`default_nettype wire

/* rtl/md_hash_message_padder.sv */
// ----------------------------------------------------------------------------
// md_hash_message_padder: byte-serial padder for 64-byte-block hashes
// Packs message bytes into 64-bit words and appends marker, zero fill and
// the 64-bit bit length trailer on a finish item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): opcode_i 0 carries one message
//   byte in data_byte_i, opcode_i 1 finishes the message.
//   Output channel (out_valid_o / out_stall_i): out_word_o holds eight
//   padded-stream bytes, earliest in bits 63..56; is_last_o flags the final
//   word of a message.
//   Config channel (cfg_valid_i / cfg_ready_o, always ready): index 0 sets
//   trailer_bytes (used saturated to 8..16), index 1 sets the length byte
//   order; other indexes are ignored. Write only while the block is idle.
// Timing:
//   A data byte is shifted in when accepted; the word it completes is on the
//   output in the next cycle. A finish item starts the sequencer, then the
//   padding goes through the byte shifter one byte per cycle while the output
//   takes its words: 1 + zero fill + trailer bytes, 9 to 80 bytes, up to ten
//   words. The input is stalled for that time and whenever a word is
//   completed while the output register still holds an unaccepted word.
// Reset clears the byte count, the word shifter, the sequencer and the
// output valid flag; the config registers return to 8 bytes, big-endian.
// ----------------------------------------------------------------------------
`default_nettype none

module md_hash_message_padder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic                          opcode_i,
  input  wire logic [7:0]                    data_byte_i,
  // result items
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [mhp_pkg::WORD_W-1:0]    out_word_o,
  output      logic                          is_last_o,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [mhp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mhp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import mhp_pkg::*;

  // configuration registers
  logic [TRAIL_W-1:0] trailer_q, trailer_d;
  logic               len_le_q, len_le_d;

  // control state
  state_e             state_q, state_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [POS_W-1:0]   pad_q, pad_d;
  logic [TRAIL_W-1:0] trl_q, trl_d;
  logic [TRAIL_W-1:0] tidx_q, tidx_d;
  logic               out_valid_q, out_valid_d;

  // payload state
  logic [BUF_W-1:0]   buf_q, buf_d;
  logic [WORD_W-1:0]  len_q, len_d;
  logic [WORD_W-1:0]  out_word_q, out_word_d;
  logic               out_last_q, out_last_d;

  // byte shifter controls
  logic               push_en;
  logic [7:0]         push_byte;
  logic               push_last;
  logic               completes;
  logic               out_free;
  logic               push_ok;
  logic               in_accept;
  logic               is_len;
  logic [TRAIL_W-1:0] trail_sat;

  // config writes, always taken
  assign cfg_ready_o = 1'b1;

  always_comb begin
    trailer_d = trailer_q;
    len_le_d  = len_le_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TRAILER_BYTES: trailer_d = cfg_data_i[TRAIL_W-1:0];
        CFG_LENGTH_LE:     len_le_d  = cfg_data_i[0];
        default:           ;
      endcase
    end
  end

  // saturated trailer size
  always_comb begin
    if (trailer_q < TRAIL_MIN) begin
      trail_sat = TRAIL_MIN;
    end else if (trailer_q > TRAIL_MAX) begin
      trail_sat = TRAIL_MAX;
    end else begin
      trail_sat = trailer_q;
    end
  end

  // output register handshake
  assign completes   = (fill_q == FILL_W'(7));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign push_ok     = !completes || out_free;
  assign in_stall_o  = (state_q != ST_IDLE) || !push_ok;
  assign in_accept   = in_valid_i && !in_stall_o;

  // length byte position inside the trailer
  always_comb begin
    if (len_le_q) begin
      is_len = (tidx_q < TRAIL_W'(LEN_BYTES));
    end else begin
      is_len = (tidx_q >= (trl_q - TRAIL_W'(LEN_BYTES)));
    end
  end

  // finish sequencer and byte source
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pad_d     = pad_q;
    trl_d     = trl_q;
    tidx_d    = tidx_q;
    len_d     = len_q;
    push_en   = 1'b0;
    push_byte = 8'h00;
    push_last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (opcode_i == OP_FINISH) begin
            pad_d   = POS_W'(6'd63 - POS_W'(trail_sat) - count_q[POS_W-1:0]);
            trl_d   = trail_sat;
            tidx_d  = '0;
            len_d   = {count_q, 3'b000};
            count_d = '0;
            state_d = ST_MARK;
          end else begin
            push_en   = 1'b1;
            push_byte = data_byte_i;
            count_d   = count_q + COUNT_W'(1);
          end
        end
      end
      ST_MARK: begin
        push_byte = PAD_MARK;
        push_en   = push_ok;
        if (push_ok) begin
          state_d = (pad_q == '0) ? ST_TRAIL : ST_ZERO;
        end
      end
      ST_ZERO: begin
        push_en = push_ok;
        if (push_ok) begin
          pad_d = pad_q - POS_W'(1);
          if (pad_q == POS_W'(1)) begin
            state_d = ST_TRAIL;
          end
        end
      end
      ST_TRAIL: begin
        if (is_len) begin
          push_byte = len_le_q ? len_q[7:0] : len_q[WORD_W-1 -: 8];
        end
        push_en   = push_ok;
        push_last = (tidx_q == (trl_q - TRAIL_W'(1)));
        if (push_ok) begin
          if (is_len) begin
            len_d = len_le_q ? {8'h00, len_q[WORD_W-1:8]} : {len_q[WORD_W-9:0], 8'h00};
          end
          tidx_d = tidx_q + TRAIL_W'(1);
          if (push_last) begin
            tidx_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // byte shifter and output word register
  always_comb begin
    buf_d       = buf_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;
    if (push_en) begin
      if (completes) begin
        out_word_d  = {buf_q, push_byte};
        out_last_d  = push_last;
        out_valid_d = 1'b1;
        buf_d       = '0;
        fill_d      = '0;
      end else begin
        buf_d  = {buf_q[BUF_W-9:0], push_byte};
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trailer_q   <= TRAIL_MIN;
      len_le_q    <= 1'b0;
      state_q     <= ST_IDLE;
      count_q     <= '0;
      fill_q      <= '0;
      pad_q       <= '0;
      trl_q       <= TRAIL_MIN;
      tidx_q      <= '0;
      out_valid_q <= 1'b0;
      buf_q       <= '0;
    end else begin
      trailer_q   <= trailer_d;
      len_le_q    <= len_le_d;
      state_q     <= state_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      pad_q       <= pad_d;
      trl_q       <= trl_d;
      tidx_q      <= tidx_d;
      out_valid_q <= out_valid_d;
      buf_q       <= buf_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign is_last_o   = out_last_q;

`ifndef ASSERT_OFF
  // a completed word never overwrites one still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_en && completes) |-> out_free)
    else $error("completed word overwrites pending output");

  // the trailer always ends exactly on a word boundary
  a_last_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_en && push_last) |-> completes)
    else $error("final trailer byte not word aligned");

  // after the final word the padder is back to an empty message
  a_clean_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_en && push_last) |=> (state_q == ST_IDLE && fill_q == '0 && count_q == '0))
    else $error("state not cleared after final word");

  // trailer index stays inside the trailer
  a_tidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRAIL) |-> (tidx_q < trl_q))
    else $error("trailer index out of range");
`endif

endmodule : md_hash_message_padder

`default_nettype wire

/* bench/md_hash_message_padder_checker.sv */
// ----------------------------------------------------------------------------
// md_hash_message_padder_checker: padded word predictor and scoreboard
// Watches the input, output and configuration channels of the padder, builds
// the expected padded words of every accepted item and compares each
// accepted output word with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module md_hash_message_padder_checker
  import mhp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel as seen at the block
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 opcode_i,
  input  logic [7:0]           data_byte_i,
  // output channel as seen at the block
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [WORD_W-1:0]    out_word_i,
  input  logic                 is_last_i,
  // configuration writes
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // results for the testbench top
  output int                   error_count_o,
  output int                   words_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } padded_word_t;

  // predicted words not yet seen on the output
  padded_word_t padded_words_q[$];
  padded_word_t oldest;

  // shadow of the block state and its registers
  logic [COUNT_W-1:0] msg_byte_count;
  logic [BUF_W-1:0]   pack_buf;
  logic [FILL_W-1:0]  pack_fill;
  logic [TRAIL_W-1:0] trailer_cfg;
  logic               len_le_cfg;

  // pack one stream byte, a word is complete after eight
  task automatic shift_byte(input logic [7:0] b);
    logic [WORD_W-1:0] acc;
    padded_word_t      w;
    acc = {pack_buf, b};
    if (pack_fill == FILL_W'(LEN_BYTES - 1)) begin
      w.word = acc;
      w.last = 1'b0;
      padded_words_q.push_back(w);
      pack_buf  = '0;
      pack_fill = '0;
    end else begin
      pack_buf  = acc[BUF_W-1:0];
      pack_fill = pack_fill + 1'b1;
    end
  endtask

  // marker, zero fill and bit length trailer closing the message
  task automatic finish_message();
    int unsigned       trail;
    int unsigned       zeros;
    int unsigned       i;
    logic [WORD_W-1:0] bit_len;
    if (trailer_cfg < TRAIL_MIN) trail = 32'(TRAIL_MIN);
    else if (trailer_cfg > TRAIL_MAX) trail = 32'(TRAIL_MAX);
    else trail = 32'(trailer_cfg);
    zeros   = (BLOCK_BYTES - 1 - trail - 32'(msg_byte_count[POS_W-1:0])) & (BLOCK_BYTES - 1);
    bit_len = {msg_byte_count, 3'b000};
    shift_byte(PAD_MARK);
    repeat (zeros) shift_byte(8'h00);
    if (len_le_cfg) begin
      for (i = 0; i < LEN_BYTES; i++) shift_byte(bit_len[8*i +: 8]);
      repeat (trail - LEN_BYTES) shift_byte(8'h00);
    end else begin
      repeat (trail - LEN_BYTES) shift_byte(8'h00);
      for (i = 0; i < LEN_BYTES; i++) shift_byte(bit_len[8*(LEN_BYTES-1-i) +: 8]);
    end
    // the padded length is a whole number of blocks, so the last byte closes a word
    padded_words_q[padded_words_q.size()-1].last = 1'b1;
    msg_byte_count = '0;
    pack_buf       = '0;
    pack_fill      = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      padded_words_q.delete();
      msg_byte_count  = '0;
      pack_buf        = '0;
      pack_fill       = '0;
      trailer_cfg     = TRAIL_MIN;
      len_le_cfg      = 1'b0;
      error_count_o   = 0;
      words_pending_o = 0;
    end else begin
      // accepted word against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (padded_words_q.size() == 0) begin
          $error("out_word: expected none, actual %h (is_last %0b)", out_word_i, is_last_i);
          error_count_o++;
        end else begin
          oldest = padded_words_q.pop_front();
          if (out_word_i !== oldest.word) begin
            $error("out_word: expected %h, actual %h", oldest.word, out_word_i);
            error_count_o++;
          end
          if (is_last_i !== oldest.last) begin
            $error("is_last: expected %0b, actual %0b", oldest.last, is_last_i);
            error_count_o++;
          end
        end
      end
      // accepted item
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_FINISH) begin
          finish_message();
        end else begin
          shift_byte(data_byte_i);
          msg_byte_count = msg_byte_count + 1'b1;
        end
      end
      // register write, unknown indexes change nothing
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TRAILER_BYTES: trailer_cfg = cfg_data_i[TRAIL_W-1:0];
          CFG_LENGTH_LE:     len_le_cfg  = cfg_data_i[0];
          default: ;
        endcase
      end
      words_pending_o = padded_words_q.size();
    end
  end

endmodule

/* bench/md_hash_message_padder_tb.sv */
// ----------------------------------------------------------------------------
// md_hash_message_padder_tb: testbench for the message padder
// Sends byte messages and finish items with random gaps and output stalls
// across several trailer sizes and length byte orders; the checker predicts
// and compares every padded word.
// ----------------------------------------------------------------------------
module md_hash_message_padder_tb;
  import mhp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // indexes past the register list, writes there are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam int ITEM_TARGET   = 230;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_GAP       = 14;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  opcode = OP_DATA;
  logic [7:0]            data_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WORD_W-1:0]     out_word;
  logic                  is_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int error_count;
  int words_pending;
  int items_sent = 0;
  bit quiet = 1'b0;

  md_hash_message_padder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .opcode_i    (opcode),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .is_last_o   (is_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  md_hash_message_padder_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .opcode_i        (opcode),
    .data_byte_i     (data_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_word_i      (out_word),
    .is_last_i       (is_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .error_count_o   (error_count),
    .words_pending_o (words_pending)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one item, after a random gap; valid stays high until the next gap
  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_bytes(input int n);
    repeat (n) send_item(OP_DATA, 8'($urandom));
  endtask

  // register write while the block is idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain every predicted word, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stall before each word
  initial begin
    int gap;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // stimulus and verdict
  initial begin
    logic [TRAIL_W-1:0] trail;
    int                 eff;
    int                 len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message at reset settings
    send_item(OP_FINISH, 8'h00);
    // extreme byte values, big-endian length
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, 8'h5A);
    send_item(OP_DATA, 8'hA5);
    send_item(OP_FINISH, 8'hFF);
    settle();

    // trailer below range is used as 8, upper data bits of the order register dropped
    cfg_write(CFG_TRAILER_BYTES, 5'd0);
    cfg_write(CFG_LENGTH_LE, 5'h1F);
    cfg_write(CFG_SPARE_2, 5'h1F);
    cfg_write(CFG_SPARE_3, 5'h0A);
    send_item(OP_DATA, 8'h80);
    send_item(OP_FINISH, 8'h00);
    settle();

    // trailer above range is used as 16
    cfg_write(CFG_TRAILER_BYTES, 5'h1F);
    send_bytes(7);
    send_item(OP_FINISH, 8'h00);
    settle();

    // widest legal trailer, big-endian
    cfg_write(CFG_TRAILER_BYTES, TRAIL_MAX);
    cfg_write(CFG_LENGTH_LE, 5'h1E);
    send_bytes(8);
    send_item(OP_FINISH, 8'h00);
    settle();

    // random phases: new settings, then a few messages
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 4))
        0:       trail = TRAIL_MIN;
        1:       trail = TRAIL_MAX;
        2:       trail = '0;
        3:       trail = '1;
        default: trail = TRAIL_W'($urandom_range(0, 31));
      endcase
      cfg_write(CFG_TRAILER_BYTES, trail);
      cfg_write(CFG_LENGTH_LE, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 3) == 0)
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_DATA_W'($urandom));
      quiet = ($urandom_range(0, 3) == 0);
      if (trail < TRAIL_MIN) eff = int'(TRAIL_MIN);
      else if (trail > TRAIL_MAX) eff = int'(TRAIL_MAX);
      else eff = int'(trail);
      repeat ($urandom_range(1, 3)) begin
        // short messages, or lengths around where the fill spills into a new block
        if ($urandom_range(0, 9) < 6) len = $urandom_range(0, 15);
        else len = BLOCK_BYTES - eff - 3 + $urandom_range(0, 4);
        send_bytes(len);
        send_item(OP_FINISH, 8'($urandom));
      end
      // sometimes a message stays open across a settings change
      if ($urandom_range(0, 3) == 0) send_bytes($urandom_range(1, 12));
      settle();
    end

    if (error_count == 0 && words_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
